// File: src/kevc_pkg.sv
// shared types, constants and helpers for the k-mer extension vote chooser
`timescale 1ns / 1ps
`default_nettype none

package kevc_pkg;

    // fixed field widths
    localparam int DEPTH_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int RATING_W   = 3;
    localparam int CODE_W     = 3;
    localparam int THRESH_W   = 3;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_BASES  = 4;
    localparam int NUM_PAIRS  = 6;
    localparam int QUEUE_DEPTH = 2;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 12;

    // register reset values
    localparam logic [FRAC_W-1:0]   VIABLE_FRACTION_RST   = 16'd819;
    localparam logic [FRAC_W-1:0]   EXPECTED_FRACTION_RST = 16'd1229;
    localparam logic [THRESH_W-1:0] RATING_THRESHOLD_RST  = 3'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_VIABLE_FRACTION   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_FRACTION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATING_THRESHOLD  = 2'd2;

    localparam int DEPTH_FLOOR = 2;

    // ratings
    localparam logic [RATING_W-1:0] RATING_NONE      = 3'd0;
    localparam logic [RATING_W-1:0] RATING_SINGLE    = 3'd1;
    localparam logic [RATING_W-1:0] RATING_LOW       = 3'd2;
    localparam logic [RATING_W-1:0] RATING_LOW_TOP   = 3'd3;
    localparam logic [RATING_W-1:0] RATING_FAIR      = 3'd4;
    localparam logic [RATING_W-1:0] RATING_HIQ_LOW   = 3'd5;
    localparam logic [RATING_W-1:0] RATING_HIQ_FAIR  = 3'd6;
    localparam logic [RATING_W-1:0] RATING_MAX       = 3'd7;
    localparam logic [RATING_W-1:0] RATING_CAP_SIX   = 3'd4;

    // extension codes
    localparam logic [CODE_W-1:0] CODE_FORK = 3'd4;
    localparam logic [CODE_W-1:0] CODE_NONE = 3'd5;

    // ratings plus pairwise order flags; flag set means the later base ranks above
    typedef struct packed {
        logic [NUM_PAIRS-1:0]                beats;
        logic [NUM_BASES-1:0][RATING_W-1:0]  rating;
    } kevc_class_t;

    // pair flag for bases i < j
    function automatic logic beat_of(input logic [NUM_PAIRS-1:0] beats,
                                     input logic [1:0] i, input logic [1:0] j);
        logic r;
        r = 1'b0;
        unique case ({i, j})
            4'b0001: r = beats[0];
            4'b0010: r = beats[1];
            4'b0011: r = beats[2];
            4'b0110: r = beats[3];
            4'b0111: r = beats[4];
            4'b1011: r = beats[5];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/kevc_front.sv
// front pipeline: thresholds, base ratings and pairwise ranking flags
`timescale 1ns / 1ps
`default_nettype none

module kevc_front #(
    parameter int COUNT_WIDTH   = kevc_pkg::COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = kevc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [8*COUNT_WIDTH+kevc_pkg::DEPTH_W-1:0] s_tdata,
    input  wire logic [kevc_pkg::FRAC_W-1:0]            viable_fraction,
    input  wire logic [kevc_pkg::FRAC_W-1:0]            expected_fraction,
    output logic                                        q_valid,
    input  wire logic                                   q_ready,
    output kevc_pkg::kevc_class_t                       q_class,
    output logic [kevc_pkg::NUM_BASES-1:0][COUNT_WIDTH-1:0] q_all
);

    localparam int NB = kevc_pkg::NUM_BASES;
    localparam int PW = kevc_pkg::FRAC_W + kevc_pkg::DEPTH_W;
    localparam int SW = (COUNT_WIDTH + FRACTION_BITS > PW) ? COUNT_WIDTH + FRACTION_BITS : PW;
    localparam logic [PW-1:0] FLOOR = PW'(kevc_pkg::DEPTH_FLOOR) << FRACTION_BITS;

    logic [NB-1:0][COUNT_WIDTH-1:0] in_hi, in_all;
    logic [kevc_pkg::DEPTH_W-1:0]   in_depth;

    logic                           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                           s1_ready, s2_ready, s3_ready;
    logic [NB-1:0][COUNT_WIDTH-1:0] s1_hi_reg, s1_all_reg, s2_hi_reg, s2_all_reg, s3_all_reg;
    logic [PW-1:0]                  s1_tv_reg, s1_te_reg;
    logic [NB-1:0][kevc_pkg::RATING_W-1:0] s2_rating_reg, rating_next;
    logic [kevc_pkg::NUM_PAIRS-1:0] beats_next;
    kevc_pkg::kevc_class_t          s3_class_reg;

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            in_hi[i]  = s_tdata[i*COUNT_WIDTH +: COUNT_WIDTH];
            in_all[i] = s_tdata[(i+NB)*COUNT_WIDTH +: COUNT_WIDTH];
        end
        in_depth = s_tdata[2*NB*COUNT_WIDTH +: kevc_pkg::DEPTH_W];
    end

    assign s3_ready = !s3_valid_reg || q_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    // stage 1: threshold products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s1_ready && s_tvalid) begin
            s1_hi_reg  <= in_hi;
            s1_all_reg <= in_all;
            s1_tv_reg  <= PW'(viable_fraction) * PW'(in_depth);
            s1_te_reg  <= PW'(expected_fraction) * PW'(in_depth);
        end
    end

    // stage 2: ratings
    always_comb begin
        logic [SW-1:0] tv, te, ns, hs;
        tv = SW'((s1_tv_reg > FLOOR) ? s1_tv_reg : FLOOR);
        te = SW'((s1_te_reg > FLOOR) ? s1_te_reg : FLOOR);
        for (int i = 0; i < NB; i++) begin
            ns = SW'(s1_all_reg[i]) << FRACTION_BITS;
            hs = SW'(s1_hi_reg[i]) << FRACTION_BITS;
            if (s1_all_reg[i] == '0) begin
                rating_next[i] = kevc_pkg::RATING_NONE;
            end else if (s1_all_reg[i] == COUNT_WIDTH'(1)) begin
                rating_next[i] = kevc_pkg::RATING_SINGLE;
            end else if (ns < tv) begin
                rating_next[i] = kevc_pkg::RATING_LOW;
            end else if (ns < te) begin
                rating_next[i] = (hs < tv) ? kevc_pkg::RATING_LOW_TOP : kevc_pkg::RATING_FAIR;
            end else if (hs < tv) begin
                rating_next[i] = kevc_pkg::RATING_HIQ_LOW;
            end else if (tv < hs && hs < te) begin
                rating_next[i] = kevc_pkg::RATING_HIQ_FAIR;
            end else begin
                rating_next[i] = kevc_pkg::RATING_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_hi_reg     <= s1_hi_reg;
            s2_all_reg    <= s1_all_reg;
            s2_rating_reg <= rating_next;
        end
    end

    // stage 3: pairwise ranking, later base above earlier only on strict win
    always_comb begin
        int p;
        p = 0;
        beats_next = '0;
        for (int i = 0; i < NB; i++) begin
            for (int j = i + 1; j < NB; j++) begin
                beats_next[p] = (s2_rating_reg[j] > s2_rating_reg[i]) ||
                                (s2_rating_reg[j] == s2_rating_reg[i] &&
                                 (s2_hi_reg[j] > s2_hi_reg[i] ||
                                  (s2_hi_reg[j] == s2_hi_reg[i] &&
                                   s2_all_reg[j] > s2_all_reg[i])));
                p = p + 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_all_reg          <= s2_all_reg;
            s3_class_reg.rating <= s2_rating_reg;
            s3_class_reg.beats  <= beats_next;
        end
    end

    assign q_valid = s3_valid_reg;
    assign q_class = s3_class_reg;
    assign q_all   = s3_all_reg;

endmodule

`default_nettype wire

// File: src/kevc_queue.sv
// small first-in first-out queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module kevc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kevc_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: src/kevc_back.sv
// back end: order bases, choose the extension and hold the result beat
`timescale 1ns / 1ps
`default_nettype none

module kevc_back #(
    parameter int COUNT_WIDTH = kevc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic [kevc_pkg::THRESH_W-1:0]               rating_threshold,
    input  wire logic                                        q_valid,
    output logic                                             q_ready,
    input  wire kevc_pkg::kevc_class_t                       q_class,
    input  wire logic [kevc_pkg::NUM_BASES-1:0][COUNT_WIDTH-1:0] q_all,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [kevc_pkg::OUT_DATA_W-1:0]                  m_tdata
);

    localparam int NB = kevc_pkg::NUM_BASES;

    logic [NB-1:0][1:0]                 pos;
    logic [1:0]                         sel0, sel1, sel2;
    logic [kevc_pkg::RATING_W-1:0]      r0, r1, r2;
    logic [COUNT_WIDTH-1:0]             a0, a1;
    logic [kevc_pkg::CODE_W-1:0]        code_next;
    logic                               m_valid_reg;
    logic [kevc_pkg::OUT_DATA_W-1:0]    m_data_reg, m_data_next;

    // rank of each base is the count of bases placed ahead of it
    always_comb begin
        logic ahead;
        for (int k = 0; k < NB; k++) begin
            pos[k] = 2'd0;
            for (int m = 0; m < NB; m++) begin
                if (m < k) begin
                    ahead = !kevc_pkg::beat_of(q_class.beats, 2'(m), 2'(k));
                end else if (m > k) begin
                    ahead = kevc_pkg::beat_of(q_class.beats, 2'(k), 2'(m));
                end else begin
                    ahead = 1'b0;
                end
                pos[k] = pos[k] + 2'(ahead);
            end
        end
    end

    always_comb begin
        sel0 = 2'd0;
        sel1 = 2'd0;
        sel2 = 2'd0;
        for (int k = 0; k < NB; k++) begin
            case (pos[k])
                2'd0:    sel0 = 2'(k);
                2'd1:    sel1 = 2'(k);
                2'd2:    sel2 = 2'(k);
                default: ;
            endcase
        end
    end

    assign r0 = q_class.rating[sel0];
    assign r1 = q_class.rating[sel1];
    assign r2 = q_class.rating[sel2];
    assign a0 = q_all[sel0];
    assign a1 = q_all[sel1];

    always_comb begin
        code_next = kevc_pkg::CODE_NONE;
        if (r0 > rating_threshold) begin
            if (r0 <= kevc_pkg::RATING_LOW_TOP) begin
                if (r1 == kevc_pkg::RATING_NONE) code_next = 3'(sel0);
            end else if (r0 < kevc_pkg::RATING_HIQ_FAIR) begin
                if (r1 < kevc_pkg::RATING_LOW_TOP) code_next = 3'(sel0);
            end else if (r0 == kevc_pkg::RATING_HIQ_FAIR) begin
                if (r1 < kevc_pkg::RATING_CAP_SIX) code_next = 3'(sel0);
            end else if (r1 < kevc_pkg::RATING_MAX) begin
                code_next = 3'(sel0);
            end else if (r2 == kevc_pkg::RATING_MAX || a0 == a1) begin
                code_next = kevc_pkg::CODE_FORK;
            end else if (a0 > a1) begin
                code_next = 3'(sel0);
            end else begin
                code_next = 3'(sel1);
            end
        end
        m_data_next = kevc_pkg::OUT_DATA_W'({r1, r0, code_next});
    end

    assign q_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_ready) begin
            m_valid_reg <= q_valid;
        end
        if (q_ready && q_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: src/kmer_extension_vote_chooser_top.sv
// top level: configuration registers, front pipeline, queue and back end
// path: front stage 1, 2 and 3 registers, queue, back end result register
// throughput: one beat per cycle while m_tready holds high, set by the three-stage
// front pipeline and the back end; the two-entry queue lets either side stall alone
// reset clears all valid flags and the queue, and loads the configuration
// registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module kmer_extension_vote_chooser_top #(
    parameter int COUNT_WIDTH   = kevc_pkg::COUNT_WIDTH_DEF,
    parameter int FRACTION_BITS = kevc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // hi_count_a, hi_count_c, hi_count_g, hi_count_t,
    // all_count_a, all_count_c, all_count_g, all_count_t, contig_depth
    input  wire logic [8*COUNT_WIDTH+kevc_pkg::DEPTH_W-1:0] s_tdata,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // extension_code, lead base rating, second base rating, zero fill
    output logic [kevc_pkg::OUT_DATA_W-1:0]                 m_tdata,
    input  wire logic                                       cfg_wr_en,
    input  wire logic [kevc_pkg::CFG_ADDR_W-1:0]            cfg_wr_addr,
    input  wire logic [kevc_pkg::CFG_DATA_W-1:0]            cfg_wr_data
);

    localparam int NB = kevc_pkg::NUM_BASES;
    localparam int QW = $bits(kevc_pkg::kevc_class_t) + NB * COUNT_WIDTH;

    logic [kevc_pkg::FRAC_W-1:0]   viable_fraction_reg, expected_fraction_reg;
    logic [kevc_pkg::THRESH_W-1:0] rating_threshold_reg;

    logic                              fq_valid, fq_ready, bq_valid, bq_ready;
    kevc_pkg::kevc_class_t             fq_class, bq_class;
    logic [NB-1:0][COUNT_WIDTH-1:0]    fq_all, bq_all;
    logic [QW-1:0]                     bq_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            viable_fraction_reg   <= kevc_pkg::VIABLE_FRACTION_RST;
            expected_fraction_reg <= kevc_pkg::EXPECTED_FRACTION_RST;
            rating_threshold_reg  <= kevc_pkg::RATING_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                kevc_pkg::CFG_VIABLE_FRACTION:   viable_fraction_reg   <= cfg_wr_data;
                kevc_pkg::CFG_EXPECTED_FRACTION: expected_fraction_reg <= cfg_wr_data;
                kevc_pkg::CFG_RATING_THRESHOLD:
                    rating_threshold_reg <= cfg_wr_data[kevc_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    kevc_front #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .viable_fraction   (viable_fraction_reg),
        .expected_fraction (expected_fraction_reg),
        .q_valid           (fq_valid),
        .q_ready           (fq_ready),
        .q_class           (fq_class),
        .q_all             (fq_all)
    );

    kevc_queue #(
        .WIDTH (QW),
        .DEPTH (kevc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_all, fq_class}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    assign bq_class = bq_data[$bits(kevc_pkg::kevc_class_t)-1:0];
    assign bq_all   = bq_data[QW-1:$bits(kevc_pkg::kevc_class_t)];

    kevc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rating_threshold (rating_threshold_reg),
        .q_valid          (bq_valid),
        .q_ready          (bq_ready),
        .q_class          (bq_class),
        .q_all            (bq_all),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/kevc_vote_checker.sv
// checker for the vote chooser: predicts each choice and compares result beats
`timescale 1ns / 1ps

module kevc_vote_checker
    import kevc_pkg::*;
(
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        s_tvalid,
    input  wire logic                                        s_tready,
    input  wire logic [8*COUNT_WIDTH_DEF+DEPTH_W-1:0]        s_tdata,
    input  wire logic                                        m_tvalid,
    input  wire logic                                        m_tready,
    input  wire logic [OUT_DATA_W-1:0]                       m_tdata,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]                       cfg_wr_addr,
    input  wire logic [CFG_DATA_W-1:0]                       cfg_wr_data,
    output int                                               mismatch_count,
    output int                                               outstanding
);

    localparam int CW         = COUNT_WIDTH_DEF;
    localparam int FRAC_SHIFT = FRACTION_BITS_DEF;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [RATING_W-1:0] top;
        logic [RATING_W-1:0] runner;
    } vote_choice_t;

    logic [FRAC_W-1:0]   viable_frac   = VIABLE_FRACTION_RST;
    logic [FRAC_W-1:0]   expected_frac = EXPECTED_FRACTION_RST;
    logic [THRESH_W-1:0] extend_floor  = RATING_THRESHOLD_RST;

    vote_choice_t expected_choices[$];

    function automatic logic [47:0] depth_threshold(input logic [FRAC_W-1:0] frac,
                                                    input logic [DEPTH_W-1:0] depth);
        logic [47:0] prod;
        logic [47:0] floor_v;
        prod = 48'(frac) * 48'(depth);
        floor_v = 48'(DEPTH_FLOOR) << FRAC_SHIFT;
        return (prod > floor_v) ? prod : floor_v;
    endfunction

    function automatic logic [RATING_W-1:0] rate_vote(input logic [CW-1:0] hq,
                                                      input logic [CW-1:0] any_q,
                                                      input logic [47:0] tv,
                                                      input logic [47:0] te);
        logic [47:0] ns;
        logic [47:0] hs;
        ns = 48'(any_q) << FRAC_SHIFT;
        hs = 48'(hq) << FRAC_SHIFT;
        if (any_q == 0) return RATING_NONE;
        if (any_q == 1) return RATING_SINGLE;
        if (ns < tv) return RATING_LOW;
        if (ns < te) return (hs < tv) ? RATING_LOW_TOP : RATING_FAIR;
        if (hs < tv) return RATING_HIQ_LOW;
        if (tv < hs && hs < te) return RATING_HIQ_FAIR;
        return RATING_MAX;
    endfunction

    function automatic vote_choice_t choose_extension(
            input logic [8*CW+DEPTH_W-1:0] beat);
        logic [CW-1:0]       hq_votes [NUM_BASES];
        logic [CW-1:0]       all_votes [NUM_BASES];
        logic [RATING_W-1:0] rating [NUM_BASES];
        int                  order [NUM_BASES];
        int                  pos;
        logic [DEPTH_W-1:0]  depth;
        logic [47:0]         tv;
        logic [47:0]         te;
        logic [RATING_W-1:0] r0;
        logic [RATING_W-1:0] r1;
        vote_choice_t        c;
        depth = beat[8*CW +: DEPTH_W];
        tv = depth_threshold(viable_frac, depth);
        te = depth_threshold(expected_frac, depth);
        for (int i = 0; i < NUM_BASES; i++) begin
            hq_votes[i] = beat[i*CW +: CW];
            all_votes[i] = beat[(i+4)*CW +: CW];
            rating[i] = rate_vote(hq_votes[i], all_votes[i], tv, te);
        end
        // descending rank, full ties keep base order
        for (int i = 0; i < NUM_BASES; i++) begin
            pos = 0;
            for (int j = 0; j < NUM_BASES; j++) begin
                if (j != i && (rating[j] > rating[i] ||
                        (rating[j] == rating[i] && (hq_votes[j] > hq_votes[i] ||
                        (hq_votes[j] == hq_votes[i] && (all_votes[j] > all_votes[i] ||
                        (all_votes[j] == all_votes[i] && j < i)))))))
                    pos++;
            end
            order[pos] = i;
        end
        r0 = rating[order[0]];
        r1 = rating[order[1]];
        c.code = CODE_NONE;
        c.top = r0;
        c.runner = r1;
        if (r0 > extend_floor) begin
            if (r0 <= RATING_LOW_TOP) begin
                if (r1 == RATING_NONE) c.code = CODE_W'(order[0]);
            end else if (r0 < RATING_HIQ_FAIR) begin
                if (r1 < RATING_LOW_TOP) c.code = CODE_W'(order[0]);
            end else if (r0 == RATING_HIQ_FAIR) begin
                if (r1 < RATING_CAP_SIX) c.code = CODE_W'(order[0]);
            end else if (r1 < RATING_MAX) begin
                c.code = CODE_W'(order[0]);
            end else if (rating[order[2]] == RATING_MAX ||
                         all_votes[order[0]] == all_votes[order[1]]) begin
                c.code = CODE_FORK;
            end else if (all_votes[order[0]] > all_votes[order[1]]) begin
                c.code = CODE_W'(order[0]);
            end else begin
                c.code = CODE_W'(order[1]);
            end
        end
        return c;
    endfunction

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        vote_choice_t want;
        if (!aresetn) begin
            viable_frac = VIABLE_FRACTION_RST;
            expected_frac = EXPECTED_FRACTION_RST;
            extend_floor = RATING_THRESHOLD_RST;
            expected_choices.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_choices.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_choices.pop_front();
                    check_field("extension_code", want.code, m_tdata[2:0]);
                    check_field("lead base rating", want.top, m_tdata[5:3]);
                    check_field("second base rating", want.runner, m_tdata[8:6]);
                end
            end
            if (s_tvalid && s_tready)
                expected_choices.insert(expected_choices.size(), choose_extension(s_tdata));
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_VIABLE_FRACTION:   viable_frac = cfg_wr_data[FRAC_W-1:0];
                    CFG_EXPECTED_FRACTION: expected_frac = cfg_wr_data[FRAC_W-1:0];
                    CFG_RATING_THRESHOLD:  extend_floor = cfg_wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_choices.size();
    end

endmodule

// File: tb/tb_kmer_extension_vote_chooser_top.sv
// testbench top for the vote chooser: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_kmer_extension_vote_chooser_top;
    import kevc_pkg::*;

    localparam int CW              = COUNT_WIDTH_DEF;
    localparam int S_W             = 8*CW + DEPTH_W;
    localparam int FRAC_SHIFT      = FRACTION_BITS_DEF;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int mismatch_count;
    int outstanding;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    logic [FRAC_W-1:0]   cur_vf = VIABLE_FRACTION_RST;
    logic [FRAC_W-1:0]   cur_ef = EXPECTED_FRACTION_RST;

    always #10 aclk = ~aclk;

    kmer_extension_vote_chooser_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    kevc_vote_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_addr    (cfg_wr_addr),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [S_W-1:0] pack_votes(
            input logic [CW-1:0] ha, input logic [CW-1:0] hc,
            input logic [CW-1:0] hg, input logic [CW-1:0] ht,
            input logic [CW-1:0] aa, input logic [CW-1:0] ac,
            input logic [CW-1:0] ag, input logic [CW-1:0] at,
            input logic [DEPTH_W-1:0] depth);
        return {depth, at, ag, ac, aa, ht, hg, hc, ha};
    endfunction

    function automatic logic [CW-1:0] clip_count(input longint x);
        if (x < 0) return '0;
        if (x > 65535) return '1;
        return CW'(x);
    endfunction

    // counts straddling a threshold boundary
    function automatic logic [CW-1:0] near_count(input longint b);
        return clip_count(b + longint'($urandom_range(2)) - 1);
    endfunction

    function automatic logic [S_W-1:0] random_votes();
        logic [CW-1:0]      hq [NUM_BASES];
        logic [CW-1:0]      aq [NUM_BASES];
        logic [DEPTH_W-1:0] depth;
        longint             v;
        longint             e;
        int                 src;
        int                 dst;
        case ($urandom_range(9))
            0:       depth = '0;
            1, 2:    depth = $urandom;
            default: depth = $urandom_range(300);
        endcase
        v = (longint'(cur_vf) * longint'(depth)) >> FRAC_SHIFT;
        e = (longint'(cur_ef) * longint'(depth)) >> FRAC_SHIFT;
        if (v < DEPTH_FLOOR) v = DEPTH_FLOOR;
        if (e < DEPTH_FLOOR) e = DEPTH_FLOOR;
        for (int i = 0; i < NUM_BASES; i++) begin
            case ($urandom_range(9))
                0:          aq[i] = '0;
                1:          aq[i] = 1;
                2, 3, 4:    aq[i] = near_count(v);
                5, 6, 7:    aq[i] = near_count(e);
                8:          aq[i] = $urandom_range(clip_count(2 * e));
                default:    aq[i] = $urandom;
            endcase
            case ($urandom_range(7))
                0:       hq[i] = near_count(v);
                1:       hq[i] = near_count(e);
                2:       hq[i] = (v < e) ? clip_count(v + $urandom_range(clip_count(e - v)))
                                         : near_count(v);
                3:       hq[i] = $urandom_range(aq[i]);
                4:       hq[i] = aq[i];
                5:       hq[i] = '0;
                default: hq[i] = $urandom;
            endcase
        end
        // ties between bases
        if ($urandom_range(2) != 0) begin
            src = $urandom_range(NUM_BASES - 1);
            dst = $urandom_range(NUM_BASES - 1);
            hq[dst] = hq[src];
            aq[dst] = aq[src];
        end
        return pack_votes(hq[0], hq[1], hq[2], hq[3], aq[0], aq[1], aq[2], aq[3], depth);
    endfunction

    task automatic send_votes(input logic [S_W-1:0] beat);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off until every result beat is back and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [FRAC_W-1:0] vf, input logic [FRAC_W-1:0] ef,
                                input logic [THRESH_W-1:0] rt);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= CFG_VIABLE_FRACTION;
        cfg_wr_data <= CFG_DATA_W'(vf);
        @(negedge aclk);
        cfg_wr_addr <= CFG_EXPECTED_FRACTION;
        cfg_wr_data <= CFG_DATA_W'(ef);
        @(negedge aclk);
        cfg_wr_addr <= CFG_RATING_THRESHOLD;
        cfg_wr_data <= {$urandom} << THRESH_W | CFG_DATA_W'(rt);
        @(negedge aclk);
        cfg_wr_addr <= CFG_UNUSED_INDEX;
        cfg_wr_data <= $urandom;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_vf = vf;
        cur_ef = ef;
        @(negedge aclk);
    endtask

    initial begin
        logic [FRAC_W-1:0] vf;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case (phase)
                0: begin
                    // reset configuration, depth 100 puts viable near 20 and expected near 30
                    send_votes(pack_votes(0, 0, 0, 0, 0, 0, 0, 0, 0));
                    // zero depth, high-quality votes exactly at the viable floor
                    send_votes(pack_votes(2, 0, 0, 0, 2, 0, 0, 0, 0));
                    send_votes(pack_votes(0, 40, 0, 0, 0, 40, 0, 0, 100));
                    send_votes(pack_votes(0, 0, 40, 0, 0, 0, 40, 0, 100));
                    send_votes(pack_votes(0, 0, 0, 40, 0, 0, 0, 40, 100));
                    // two top bases with equal all votes
                    send_votes(pack_votes(40, 40, 0, 0, 40, 40, 0, 0, 100));
                    send_votes(pack_votes(40, 45, 0, 0, 50, 60, 0, 0, 100));
                    send_votes(pack_votes(50, 40, 0, 0, 40, 60, 0, 0, 100));
                    // three bases at the top rating
                    send_votes(pack_votes(40, 40, 40, 0, 40, 50, 60, 0, 100));
                    // full ties keep base order
                    send_votes(pack_votes(5, 5, 5, 5, 5, 5, 5, 5, 100));
                    send_votes(pack_votes(0, 0, 0, 0, 1, 0, 0, 0, 100));
                    send_votes(pack_votes(5, 0, 0, 0, 25, 0, 0, 0, 100));
                    send_votes(pack_votes(5, 0, 0, 0, 25, 1, 0, 0, 100));
                    send_votes(pack_votes(25, 0, 0, 0, 25, 10, 0, 0, 100));
                    send_votes(pack_votes(5, 5, 0, 0, 40, 25, 0, 0, 100));
                    send_votes(pack_votes(25, 25, 0, 0, 40, 25, 0, 0, 100));
                    send_votes(pack_votes(25, 5, 0, 0, 40, 25, 0, 0, 100));
                    send_votes(pack_votes('1, '1, '1, '1, '1, '1, '1, '1, '1));
                    send_votes(pack_votes(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA));
                end
                1: program_regs('0, '0, 3'd0);
                2: begin
                    program_regs('1, '1, 3'd7);
                    send_votes(pack_votes('1, '1, '1, '1, '1, '1, '1, '1, '1));
                end
                3: program_regs('1, '0, 3'd3);
                4: program_regs('0, '1, 3'd1);
                default: begin
                    vf = $urandom_range(8191);
                    program_regs(vf, vf + FRAC_W'($urandom_range(8191)), $urandom_range(5));
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2 && phase % 3 == 1) settle();
                send_votes(random_votes());
            end
        end
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/kevc_pkg.sv
src/kevc_front.sv
src/kevc_queue.sv
src/kevc_back.sv
src/kmer_extension_vote_chooser_top.sv
tb/kevc_vote_checker.sv
tb/tb_kmer_extension_vote_chooser_top.sv
